// ===== sv/grd_pkg.sv =====
// Shared types and constants for the generator ramp dispatch model.
`default_nettype none
package grd_pkg;

   localparam logic [2:0] OP_DISPATCH = 3'd0;
   localparam logic [2:0] OP_WEATHER  = 3'd1;
   localparam logic [2:0] OP_ADD_FUEL = 3'd2;
   localparam logic [2:0] OP_SET_FUEL = 3'd3;

   localparam logic [2:0] REG_CAPACITY   = 3'd0;
   localparam logic [2:0] REG_MIN_STABLE = 3'd1;
   localparam logic [2:0] REG_RAMP_STEP  = 3'd2;
   localparam logic [2:0] REG_HEAT_RATE  = 3'd3;
   localparam logic [2:0] REG_PLANT_MODE = 3'd4;
   localparam logic [2:0] REG_TRIP_FLAG  = 3'd5;

   localparam logic [1:0] MODE_DISPATCH = 2'd0;
   localparam logic [1:0] MODE_WIND     = 2'd1;
   localparam logic [1:0] MODE_SOLAR    = 2'd2;

   localparam logic [15:0] WIND_CUT_IN  = 16'd768;
   localparam logic [15:0] WIND_RATED   = 16'd3072;
   localparam logic [15:0] WIND_CUT_OUT = 16'd6400;
   // span^3 = 729 * 2^24, the power of two is taken as a shift
   localparam logic [16:0] WIND_DIV     = 17'd729;
   localparam logic [16:0] SOLAR_DIV    = 17'd1000;
   // 83886080 = 5 * 2^24
   localparam logic [16:0] BURN_DIV     = 17'd5;
   localparam logic [16:0] FRAC_ONE     = 17'h10000;
   localparam logic [19:0] BURN_BASE    = 20'd393216;
   localparam logic [21:0] BURN_MAX     = 22'h3FFFFF;
   localparam logic [15:0] MIN_DENOM    = 16'd16;
   localparam logic [31:0] FUEL_RESET   = 32'd16000;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// ===== sv/grd_if.sv =====
// Channel interfaces: event input, result output and register writes.
`default_nettype none
interface grd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  opcode;
   logic [15:0] target_power;
   logic [15:0] wind_speed;
   logic [10:0] irradiance;
   logic signed [31:0] fuel_amount;
   modport source (output valid, opcode, target_power, wind_speed, irradiance,
                   fuel_amount, input ready);
   modport sink (input valid, opcode, target_power, wind_speed, irradiance,
                 fuel_amount, output ready);
endinterface

interface grd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] output_power;
   logic [15:0] target_out;
   logic [16:0] capacity_fraction;
   logic [21:0] fuel_burn;
   modport source (output valid, output_power, target_out, capacity_fraction,
                   fuel_burn, input ready);
   modport sink (input valid, output_power, target_out, capacity_fraction,
                 fuel_burn, output ready);
endinterface

interface grd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/generator_ramp_dispatch_model.sv =====
// Generator ramp dispatch model: event sequencer around one multiplier and one divider.
//
// Usage:
//   req_ch carries one event per transaction (dispatch, weather, fuel add, fuel
//   set, tick). Each event is followed by a one-minute plant update, and exactly
//   one result transaction leaves on rsp_ch with output, target, capacity
//   fraction and fuel burn. csr_ch writes the six plant registers; it is always
//   ready and is meant to be written while no event is in flight.
// Datapath: the sequencer reuses a 36x20 multiplier and a 32-step divider.
//   Tripped, fixed-target, out-of-band and rated wind events use neither unit.
//   Solar and below-rated in-band wind take 1-3 multiplies and one division.
//   Dispatchable events take two divisions and two multiplies.
//   One event is worked at a time; req_ch.ready is low from acceptance until
//   the result has been placed in the output register.
// Stall: the result register holds until rsp_ch.ready; the next event may be
//   accepted meanwhile, but its result waits for the register to drain.
// Reset: synchronous, active high; registers return to their defaults, plant
//   state is cleared and fuel is set to 16000 units.
`default_nettype none
module generator_ramp_dispatch_model (
   input  wire logic  clock,
   input  wire logic  reset,
   grd_req_if.sink    req_ch,
   grd_rsp_if.source  rsp_ch,
   grd_csr_if.sink    csr_ch
);
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_EVENT   = 4'd1;
   localparam logic [3:0] ST_PLAN    = 4'd2;
   localparam logic [3:0] ST_WMUL1   = 4'd3;
   localparam logic [3:0] ST_WMUL2   = 4'd4;
   localparam logic [3:0] ST_WMUL3   = 4'd5;
   localparam logic [3:0] ST_SMUL    = 4'd6;
   localparam logic [3:0] ST_DIVGO   = 4'd7;
   localparam logic [3:0] ST_DIVWAIT = 4'd8;
   localparam logic [3:0] ST_SLEW    = 4'd9;
   localparam logic [3:0] ST_BMUL1   = 4'd10;
   localparam logic [3:0] ST_BMUL2   = 4'd11;
   localparam logic [3:0] ST_DONE    = 4'd12;

   localparam logic [1:0] DK_WIND  = 2'd0;
   localparam logic [1:0] DK_SOLAR = 2'd1;
   localparam logic [1:0] DK_FRAC  = 2'd2;
   localparam logic [1:0] DK_BURN  = 2'd3;

   // registers
   logic [15:0] cap_ff, msl_ff, ramp_ff;
   logic [12:0] hr_ff;
   logic [1:0]  mode_ff;
   logic        trip_ff;

   // plant state
   logic [15:0] target_ff, target_in;
   logic [15:0] out_ff, out_in;
   logic [31:0] fuel_ff, fuel_in;
   logic [15:0] wind_ff, wind_in;
   logic [10:0] sun_ff, sun_in;
   logic [16:0] held_ff, held_in;
   logic [21:0] burn_ff, burn_in;

   logic [3:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [55:0] prod_ff, prod_in;

   // captured event
   logic [2:0]  op_ff;
   logic [15:0] tp_ff, ws_ff;
   logic [10:0] irr_ff;
   logic [31:0] amt_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_out_ff, rsp_tgt_ff;
   logic [16:0] rsp_frac_ff;
   logic [21:0] rsp_burn_ff;

   logic [35:0] mul_a;
   logic [19:0] mul_b;
   logic [11:0] wind_d;
   logic [15:0] denom;
   logic [15:0] cap_min_tgt;
   logic [32:0] fuel_sum;
   logic signed [16:0] delta;
   logic [16:0] mag;
   logic [15:0] slew;
   logic [16:0] frac_sat;
   logic        req_fire, load_rsp;

   grd_pkg::div_req_type div_req;
   grd_pkg::div_rsp_type div_rsp;

   grd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign load_rsp     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   assign wind_d      = 12'(wind_ff - grd_pkg::WIND_CUT_IN);
   assign denom       = (cap_ff > grd_pkg::MIN_DENOM) ? cap_ff : grd_pkg::MIN_DENOM;
   assign cap_min_tgt = (target_ff < cap_ff) ? target_ff : cap_ff;
   assign frac_sat    = (div_rsp.quotient > {15'd0, grd_pkg::FRAC_ONE}) ?
                        grd_pkg::FRAC_ONE : div_rsp.quotient[16:0];

   // shared multiplier operand select
   always_comb begin
      mul_a = 36'd0;
      mul_b = 20'd0;
      case (state_ff)
         ST_WMUL1: begin
            mul_a = {24'd0, wind_d};
            mul_b = {8'd0, wind_d};
         end
         ST_WMUL2: begin
            mul_a = prod_ff[35:0];
            mul_b = {8'd0, wind_d};
         end
         ST_WMUL3: begin
            mul_a = prod_ff[35:0];
            mul_b = {4'd0, cap_ff};
         end
         ST_SMUL: begin
            mul_a = {20'd0, cap_ff};
            mul_b = {9'd0, sun_ff};
         end
         ST_BMUL1: begin
            mul_a = {20'd0, out_ff};
            mul_b = {7'd0, hr_ff};
         end
         ST_BMUL2: begin
            mul_a = prod_ff[35:0];
            mul_b = 20'(grd_pkg::BURN_BASE - {3'd0, held_ff});
         end
         default: begin
            mul_a = 36'd0;
            mul_b = 20'd0;
         end
      endcase
   end

   // divider operand select
   always_comb begin
      div_req.start = (state_ff == ST_DIVGO);
      case (kind_ff)
         DK_WIND: begin
            div_req.dividend = prod_ff[55:24];
            div_req.divisor  = grd_pkg::WIND_DIV;
         end
         DK_SOLAR: begin
            div_req.dividend = prod_ff[31:0];
            div_req.divisor  = grd_pkg::SOLAR_DIV;
         end
         DK_FRAC: begin
            div_req.dividend = {out_ff, 16'd0};
            div_req.divisor  = {1'b0, denom};
         end
         default: begin
            div_req.dividend = prod_ff[55:24];
            div_req.divisor  = grd_pkg::BURN_DIV;
         end
      endcase
   end

   // ramp toward target
   always_comb begin
      delta = $signed({1'b0, target_ff}) - $signed({1'b0, out_ff});
      mag   = delta[16] ? 17'(-delta) : 17'(delta);
      if (mag <= {1'b0, ramp_ff}) begin
         slew = target_ff;
      end else if (!delta[16]) begin
         slew = out_ff + ramp_ff;
      end else begin
         slew = out_ff - ramp_ff;
      end
   end

   assign fuel_sum = {fuel_ff[31], fuel_ff} + {amt_ff[31], amt_ff};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      prod_in      = prod_ff;
      target_in    = target_ff;
      out_in       = out_ff;
      fuel_in      = fuel_ff;
      wind_in      = wind_ff;
      sun_in       = sun_ff;
      held_in      = held_ff;
      burn_in      = burn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EVENT;
            end
         end
         ST_EVENT: begin
            case (op_ff)
               grd_pkg::OP_DISPATCH: begin
                  if (mode_ff == grd_pkg::MODE_DISPATCH) begin
                     target_in = (tp_ff < cap_ff) ? tp_ff : cap_ff;
                  end
               end
               grd_pkg::OP_WEATHER: begin
                  wind_in = ws_ff;
                  sun_in  = irr_ff;
               end
               grd_pkg::OP_ADD_FUEL: begin
                  if (fuel_sum[32] != fuel_sum[31]) begin
                     fuel_in = fuel_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                  end else begin
                     fuel_in = fuel_sum[31:0];
                  end
               end
               grd_pkg::OP_SET_FUEL: begin
                  fuel_in = amt_ff;
               end
               default: begin
               end
            endcase
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            burn_in = 22'd0;
            if (trip_ff) begin
               out_in   = 16'd0;
               state_in = ST_DONE;
            end else if (mode_ff == grd_pkg::MODE_WIND) begin
               if (wind_ff < grd_pkg::WIND_CUT_IN || wind_ff > grd_pkg::WIND_CUT_OUT) begin
                  target_in = 16'd0;
                  out_in    = 16'd0;
                  state_in  = ST_DONE;
               end else if (wind_ff >= grd_pkg::WIND_RATED) begin
                  target_in = cap_ff;
                  out_in    = cap_ff;
                  state_in  = ST_DONE;
               end else begin
                  kind_in  = DK_WIND;
                  state_in = ST_WMUL1;
               end
            end else if (mode_ff == grd_pkg::MODE_SOLAR) begin
               kind_in  = DK_SOLAR;
               state_in = ST_SMUL;
            end else if (mode_ff != grd_pkg::MODE_DISPATCH) begin
               out_in   = cap_min_tgt;
               state_in = ST_DONE;
            end else begin
               // empty tank: fuel at or below zero
               if (fuel_ff[31] || fuel_ff == 32'd0) begin
                  target_in = 16'd0;
               end
               state_in = ST_SLEW;
            end
         end
         ST_WMUL1: begin
            prod_in  = 56'(mul_a * mul_b);
            state_in = ST_WMUL2;
         end
         ST_WMUL2: begin
            prod_in  = 56'(mul_a * mul_b);
            state_in = ST_WMUL3;
         end
         ST_WMUL3: begin
            prod_in  = 56'(mul_a * mul_b);
            state_in = ST_DIVGO;
         end
         ST_SMUL: begin
            prod_in  = 56'(mul_a * mul_b);
            state_in = ST_DIVGO;
         end
         ST_SLEW: begin
            out_in = slew;
            // minimum stable load band
            if (slew >= 16'd2 && slew < msl_ff) begin
               out_in = (target_ff <= 16'd1) ? 16'd0 : msl_ff;
            end
            kind_in  = DK_FRAC;
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            state_in = ST_DIVWAIT;
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               case (kind_ff)
                  DK_WIND: begin
                     target_in = div_rsp.quotient[15:0];
                     out_in    = (div_rsp.quotient[15:0] < cap_ff) ?
                                 div_rsp.quotient[15:0] : cap_ff;
                     state_in  = ST_DONE;
                  end
                  DK_SOLAR: begin
                     target_in = (div_rsp.quotient > 32'h0000_FFFF) ?
                                 16'hFFFF : div_rsp.quotient[15:0];
                     out_in    = (target_in < cap_ff) ? target_in : cap_ff;
                     state_in  = ST_DONE;
                  end
                  DK_FRAC: begin
                     held_in  = frac_sat;
                     state_in = ST_BMUL1;
                  end
                  default: begin
                     burn_in  = (div_rsp.quotient > {10'd0, grd_pkg::BURN_MAX}) ?
                                grd_pkg::BURN_MAX : div_rsp.quotient[21:0];
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_BMUL1: begin
            prod_in  = 56'(mul_a * mul_b);
            state_in = ST_BMUL2;
         end
         ST_BMUL2: begin
            prod_in  = 56'(mul_a * mul_b);
            kind_in  = DK_BURN;
            state_in = ST_DIVGO;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= DK_WIND;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= 16'd800;
         msl_ff       <= 16'd160;
         ramp_ff      <= 16'd80;
         hr_ff        <= 13'd2816;
         mode_ff      <= grd_pkg::MODE_DISPATCH;
         trip_ff      <= 1'b0;
         target_ff    <= 16'd0;
         out_ff       <= 16'd0;
         fuel_ff      <= grd_pkg::FUEL_RESET;
         wind_ff      <= 16'd0;
         sun_ff       <= 11'd0;
         held_ff      <= 17'd0;
         burn_ff      <= 22'd0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         out_ff       <= out_in;
         fuel_ff      <= fuel_in;
         wind_ff      <= wind_in;
         sun_ff       <= sun_in;
         held_ff      <= held_in;
         burn_ff      <= burn_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               grd_pkg::REG_CAPACITY:   cap_ff  <= csr_ch.data;
               grd_pkg::REG_MIN_STABLE: msl_ff  <= csr_ch.data;
               grd_pkg::REG_RAMP_STEP:  ramp_ff <= csr_ch.data;
               grd_pkg::REG_HEAT_RATE:  hr_ff   <= csr_ch.data[12:0];
               grd_pkg::REG_PLANT_MODE: mode_ff <= csr_ch.data[1:0];
               grd_pkg::REG_TRIP_FLAG:  trip_ff <= csr_ch.data[0];
               default: begin
               end
            endcase
         end
      end
      prod_ff <= prod_in;
      if (req_fire) begin
         op_ff  <= req_ch.opcode;
         tp_ff  <= req_ch.target_power;
         ws_ff  <= req_ch.wind_speed;
         irr_ff <= req_ch.irradiance;
         amt_ff <= req_ch.fuel_amount;
      end
      if (load_rsp) begin
         rsp_out_ff  <= out_ff;
         rsp_tgt_ff  <= target_ff;
         rsp_frac_ff <= held_ff;
         rsp_burn_ff <= burn_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.output_power      = rsp_out_ff;
   assign rsp_ch.target_out        = rsp_tgt_ff;
   assign rsp_ch.capacity_fraction = rsp_frac_ff;
   assign rsp_ch.fuel_burn         = rsp_burn_ff;
endmodule
`default_nettype wire

// ===== sv/grd_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
`default_nettype none
module grd_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire grd_pkg::div_req_type req,
   output      grd_pkg::div_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [16:0] den_ff, den_in;
   logic [17:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 17'd0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 17'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

// ===== sv/grd_checker.sv =====
// Port-level checks for the generator ramp dispatch model, bound to the top level.
`default_nettype none
module grd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_output_power,
   input wire logic [16:0] rsp_capacity_fraction,
   input wire logic [21:0] rsp_fuel_burn
);
   // a stalled result transaction keeps its output power and fuel burn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_output_power)
                                  && $stable(rsp_fuel_burn))
      else $error("result changed while stalled");

   // an accepted event keeps the input side busy for the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted event");

   a_frac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_capacity_fraction <= 17'h10000)
      else $error("capacity fraction above one");

   // no output, no burn
   a_burn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_output_power == 16'd0 |-> rsp_fuel_burn == 22'd0)
      else $error("fuel burn with zero output");
endmodule

bind generator_ramp_dispatch_model grd_checker u_grd_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_output_power      (rsp_ch.output_power),
   .rsp_capacity_fraction (rsp_ch.capacity_fraction),
   .rsp_fuel_burn         (rsp_ch.fuel_burn)
);
`default_nettype wire

// ===== verif/tb_generator_ramp_dispatch_model.sv =====
// Testbench for the generator ramp dispatch model: directed and random events, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module tb_generator_ramp_dispatch_model;

   localparam logic [2:0] OP_TICK = 3'd4;
   localparam logic [1:0] MODE_FIXED = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] output_power;
      logic [15:0] target_out;
      logic [16:0] capacity_fraction;
      logic [21:0] fuel_burn;
   } plant_result_type;

   logic clock;
   logic reset;

   grd_req_if req_ch ();
   grd_rsp_if rsp_ch ();
   grd_csr_if csr_ch ();

   generator_ramp_dispatch_model DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch), .csr_ch(csr_ch)
   );

   // predictor copy of registers and plant state
   logic [15:0] cap_reg, min_reg, ramp_reg;
   logic [12:0] heat_reg;
   logic [1:0]  mode_reg;
   logic        trip_reg;
   logic [15:0] target_lvl, output_lvl, wind_lvl;
   logic [10:0] sun_lvl;
   logic signed [31:0] fuel_lvl;
   logic [16:0] cap_frac;

   plant_result_type expected_results[$];
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int idle_cycles = 0;
   bit stall_long = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   task automatic reset_plant_model();
      cap_reg = 16'd800; min_reg = 16'd160; ramp_reg = 16'd80; heat_reg = 13'd2816;
      mode_reg = grd_pkg::MODE_DISPATCH; trip_reg = 1'b0;
      target_lvl = '0; output_lvl = '0; wind_lvl = '0; sun_lvl = '0;
      fuel_lvl = 32'sd16000; cap_frac = '0;
   endtask

   function automatic logic [21:0] run_plant_update();
      longint unsigned d, t, f, burn, denom;
      longint delta;
      if (trip_reg) begin
         output_lvl = '0;
         return '0;
      end
      if (mode_reg != grd_pkg::MODE_DISPATCH) begin
         if (mode_reg == grd_pkg::MODE_WIND) begin
            if (wind_lvl < 768 || wind_lvl > 6400) target_lvl = '0;
            else if (wind_lvl >= 3072) target_lvl = cap_reg;
            else begin
               d = wind_lvl - 768;
               target_lvl = 16'((64'(cap_reg) * d * d * d) / (64'd2304 * 2304 * 2304));
            end
         end else if (mode_reg == grd_pkg::MODE_SOLAR) begin
            t = (64'(cap_reg) * sun_lvl) / 1000;
            target_lvl = t > 65535 ? 16'hFFFF : t[15:0];
         end
         output_lvl = target_lvl < cap_reg ? target_lvl : cap_reg;
         return '0;
      end
      if (fuel_lvl <= 0) target_lvl = '0;
      delta = longint'(target_lvl) - longint'(output_lvl);
      if ((delta < 0 ? -delta : delta) <= ramp_reg) output_lvl = target_lvl;
      else if (delta > 0) output_lvl = output_lvl + ramp_reg;
      else output_lvl = output_lvl - ramp_reg;
      if (output_lvl >= 2 && output_lvl < min_reg)
         output_lvl = (target_lvl <= 1) ? 16'd0 : min_reg;
      denom = cap_reg > 16 ? cap_reg : 16;
      f = (64'(output_lvl) << 16) / denom;
      if (f > 65536) f = 65536;
      cap_frac = f[16:0];
      burn = 64'(output_lvl) * heat_reg * (393216 - f) / 83886080;
      if (burn > 4194303) burn = 4194303;
      return burn[21:0];
   endfunction

   function automatic plant_result_type predict_event(input logic [2:0] op,
                                                      input logic [15:0] tp,
                                                      input logic [15:0] ws,
                                                      input logic [10:0] irr,
                                                      input logic signed [31:0] amt);
      plant_result_type r;
      longint s;
      logic [21:0] burn;
      case (op)
         grd_pkg::OP_DISPATCH:
            if (mode_reg == grd_pkg::MODE_DISPATCH) target_lvl = tp < cap_reg ? tp : cap_reg;
         grd_pkg::OP_WEATHER: begin
            wind_lvl = ws; sun_lvl = irr;
         end
         grd_pkg::OP_ADD_FUEL: begin
            s = longint'(fuel_lvl) + longint'(amt);
            if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
            if (s < -64'sh8000_0000) s = -64'sh8000_0000;
            fuel_lvl = s[31:0];
         end
         grd_pkg::OP_SET_FUEL: fuel_lvl = amt;
         default: ;
      endcase
      burn = run_plant_update();
      r.output_power = output_lvl; r.target_out = target_lvl;
      r.capacity_fraction = cap_frac; r.fuel_burn = burn;
      return r;
   endfunction

   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_event(input logic [2:0] op, input logic [15:0] tp, input logic [15:0] ws,
                             input logic [10:0] irr, input logic signed [31:0] amt);
      int g = gap_len();
      // valid was dropped at the last falling edge; raise it again after the gap from gap_len
      repeat (g + 1) @(negedge clock);
      req_ch.valid <= 1'b1; req_ch.opcode <= op; req_ch.target_power <= tp;
      req_ch.wind_speed <= ws; req_ch.irradiance <= irr; req_ch.fuel_amount <= amt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_results.push_back(predict_event(op, tp, ws, irr, amt));
      sent_count++;
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   task automatic drain_events();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1; csr_ch.index <= idx; csr_ch.data <= val;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         grd_pkg::REG_CAPACITY:   cap_reg = val;
         grd_pkg::REG_MIN_STABLE: min_reg = val;
         grd_pkg::REG_RAMP_STEP:  ramp_reg = val;
         grd_pkg::REG_HEAT_RATE:  heat_reg = val[12:0];
         grd_pkg::REG_PLANT_MODE: mode_reg = val[1:0];
         grd_pkg::REG_TRIP_FLAG:  trip_reg = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_event(input bit legal_only);
      logic [2:0] op;
      logic [15:0] tp, ws;
      int p = $urandom_range(0, 99);
      op = legal_only ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
      // targets mostly from zero to just above capacity, sometimes any value
      tp = (p < 70) ? 16'($urandom_range(0, cap_reg + 40)) : 16'($urandom);
      ws = (p < 75) ? 16'($urandom_range(600, 6600)) : 16'($urandom);
      send_event(op, tp, ws, 11'($urandom), (p < 15) ? 32'($urandom) :
                 32'($urandom_range(0, 4000)) - 32'd1000);
   endtask

   task automatic test_directed_dispatch();
      send_event(grd_pkg::OP_DISPATCH, 16'hFFFF, 16'h0, 11'h0, 32'sd0);
      repeat (11) send_event(OP_TICK, 16'h0, 16'h0, 11'h0, 32'sd0);
      send_event(grd_pkg::OP_DISPATCH, 16'd1, 16'hFFFF, 11'h7FF, -32'sd1);
      send_event(grd_pkg::OP_DISPATCH, 16'd100, 16'h0, 11'h0, 32'sd0);
      send_event(3'd5, 16'h0, 16'h0, 11'h0, 32'sd0);
      send_event(3'd7, 16'hFFFF, 16'hFFFF, 11'h7FF, 32'sh7FFFFFFF);
      send_event(grd_pkg::OP_ADD_FUEL, 16'h0, 16'h0, 11'h0, 32'sh7FFFFFFF);
      send_event(grd_pkg::OP_ADD_FUEL, 16'h0, 16'h0, 11'h0, 32'sh7FFFFFFF);
      send_event(grd_pkg::OP_SET_FUEL, 16'h0, 16'h0, 11'h0, 32'sh80000000);
      send_event(grd_pkg::OP_ADD_FUEL, 16'h0, 16'h0, 11'h0, 32'sh80000000);
      send_event(grd_pkg::OP_DISPATCH, 16'd500, 16'h0, 11'h0, 32'sd0);
      send_event(grd_pkg::OP_SET_FUEL, 16'h0, 16'h0, 11'h0, 32'sd0);
      send_event(grd_pkg::OP_SET_FUEL, 16'h0, 16'h0, 11'h0, 32'sd1);
      send_event(grd_pkg::OP_DISPATCH, 16'd500, 16'h0, 11'h0, 32'sd0);
      drain_events();
   endtask

   task automatic test_modes();
      logic [15:0] winds[8] = '{16'd0, 16'd767, 16'd768, 16'd2000, 16'd3071, 16'd3072,
                                16'd6400, 16'd6401};
      write_register(grd_pkg::REG_PLANT_MODE, 16'(grd_pkg::MODE_WIND));
      foreach (winds[i]) send_event(grd_pkg::OP_WEATHER, 16'h0, winds[i], 11'd0, 32'sd0);
      send_event(grd_pkg::OP_WEATHER, 16'h0, 16'hFFFF, 11'h7FF, 32'sd0);
      drain_events();
      write_register(grd_pkg::REG_PLANT_MODE, 16'(grd_pkg::MODE_SOLAR));
      write_register(grd_pkg::REG_CAPACITY, 16'hFFFF);
      send_event(grd_pkg::OP_WEATHER, 16'h0, 16'h0, 11'h7FF, 32'sd0);
      send_event(grd_pkg::OP_DISPATCH, 16'd9, 16'h0, 11'd500, 32'sd0);
      drain_events();
      write_register(grd_pkg::REG_PLANT_MODE, 16'(MODE_FIXED));
      send_event(grd_pkg::OP_DISPATCH, 16'd9, 16'h0, 11'd500, 32'sd0);
      drain_events();
      write_register(grd_pkg::REG_CAPACITY, 16'd16);
      send_event(OP_TICK, 16'h0, 16'h0, 11'h0, 32'sd0);
      drain_events();
      write_register(grd_pkg::REG_TRIP_FLAG, 16'd1);
      write_register(grd_pkg::REG_PLANT_MODE, 16'(grd_pkg::MODE_DISPATCH));
      send_event(grd_pkg::OP_DISPATCH, 16'd12, 16'h0, 11'h0, 32'sd0);
      drain_events();
      write_register(grd_pkg::REG_TRIP_FLAG, 16'd0);
   endtask

   task automatic test_random_phase(input int n, input logic [15:0] cap, input logic [15:0] mn,
                                    input logic [15:0] rs, input logic [12:0] hr,
                                    input logic [1:0] md, input logic tr);
      write_register(grd_pkg::REG_CAPACITY, cap); write_register(grd_pkg::REG_MIN_STABLE, mn);
      write_register(grd_pkg::REG_RAMP_STEP, rs);
      write_register(grd_pkg::REG_HEAT_RATE, 16'(hr));
      write_register(grd_pkg::REG_PLANT_MODE, 16'(md));
      write_register(grd_pkg::REG_TRIP_FLAG, 16'(tr));
      stall_long = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
         random_event($urandom_range(0, 9) != 0);
         // one pause until everything is back
         if (i == n / 2) while (expected_results.size() != 0) @(negedge clock);
      end
      drain_events();
   endtask

   task automatic test_random_settings();
      test_random_phase(150, 16'd800, 16'd160, 16'd80, 13'd2816, grd_pkg::MODE_DISPATCH, 1'b0);
      test_random_phase(100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'h1FFF, grd_pkg::MODE_DISPATCH,
                        1'b0);
      test_random_phase(100, 16'd16, 16'd0, 16'd0, 13'd0, grd_pkg::MODE_DISPATCH, 1'b0);
      test_random_phase(100, 16'd200, 16'd900, 16'd3, 13'd4000, grd_pkg::MODE_DISPATCH, 1'b0);
      for (int k = 0; k < 4; k++)
         test_random_phase(110, 16'($urandom_range(16, 65535)), 16'($urandom),
                           16'($urandom_range(0, 500)), 13'($urandom),
                           2'($urandom_range(0, 3)), 1'($urandom_range(0, 5) == 0));
   endtask

   // result sink with random backpressure and scoreboard check
   always @(posedge clock) begin
      plant_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         checked_count++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result transaction", checked_count, sent_count);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.output_power !== want.output_power)
               report_mismatch("output_power", rsp_ch.output_power, want.output_power);
            if (rsp_ch.target_out !== want.target_out)
               report_mismatch("target_out", rsp_ch.target_out, want.target_out);
            if (rsp_ch.capacity_fraction !== want.capacity_fraction)
               report_mismatch("capacity_fraction", rsp_ch.capacity_fraction,
                               want.capacity_fraction);
            if (rsp_ch.fuel_burn !== want.fuel_burn)
               report_mismatch("fuel_burn", rsp_ch.fuel_burn, want.fuel_burn);
         end
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= stall_long ? ($urandom_range(0, 9) < 3) : ($urandom_range(0, 9) < 8);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_generator_ramp_dispatch_model: errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.opcode = '0; req_ch.target_power = '0;
      req_ch.wind_speed = '0; req_ch.irradiance = '0; req_ch.fuel_amount = '0;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
      reset_plant_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_dispatch();
      test_modes();
      test_random_settings();
      $display("covered %0d events, %0d results, all modes, trip, fuel limits, register extremes",
               sent_count, checked_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb_generator_ramp_dispatch_model: clean");
      end else begin
         $display("tb_generator_ramp_dispatch_model: errors");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
sv/grd_pkg.sv
sv/grd_if.sv
sv/grd_div.sv
sv/generator_ramp_dispatch_model.sv
sv/grd_checker.sv
verif/tb_generator_ramp_dispatch_model.sv
